[hw/rtl/bba_pkg.sv]
// Shared constants, codes and types of the bitmap block allocator.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int MAX_BLOCKS  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = MAX_BLOCKS / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int WCNT_W      = $clog2(NUM_WORDS + 1);
    localparam int BLK_W       = 12;
    localparam int LEN_W       = 13;
    localparam int FUNC_W      = 3;
    localparam int RUN_W       = $clog2(WORD_BITS + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FUNC_W-1:0] FUNC_MARK_USED = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_MARK_FREE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEST      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIND      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_MARK_ALL  = 3'd4;

    typedef enum logic [2:0] {
        OP_SET,
        OP_CLR,
        OP_TEST,
        OP_TEST_OOR,
        OP_FIND,
        OP_NONE,
        OP_ALL
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [WORD_IDX_W-1:0] word_idx;
        logic [BIT_IDX_W-1:0]  bit_idx;
        logic [LEN_W-1:0]      len;
        logic [WCNT_W-1:0]     nwords;
    } cmd_t;

endpackage

[hw/rtl/bitmap_block_allocator_top.sv]
// Top level of the bitmap block allocator: front end, command queue and execution engine.
// A mark or in-range test item passes through the idle, access and emit states, and a mark-all,
// out-of-range test or rejected item through the idle and emit states only; the engine takes a
// new item only once the last is done. A find item reads the managed words through the
// one-word-per-cycle bitmap memory port. Up to two items queue while one executes.
// Reset is asynchronous and active low; the bitmap reads as all used at once after it.
`timescale 1ns / 1ps

module bitmap_block_allocator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bba_pkg::LEN_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bba_pkg::FUNC_W-1:0]  func,
    input  logic [bba_pkg::BLK_W-1:0]   block_index,
    input  logic [bba_pkg::LEN_W-1:0]   run_length,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        block_used,
    output logic                        found,
    output logic [bba_pkg::BLK_W-1:0]   start_block
);

    logic          q_full;
    logic          push;
    bba_pkg::cmd_t push_cmd;
    logic          q_pop;
    logic          q_valid;
    bba_pkg::cmd_t q_cmd;

    bba_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .block_index (block_index),
        .run_length  (run_length),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    bba_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    bba_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .block_used  (block_used),
        .found       (found),
        .start_block (start_block)
    );

endmodule

[hw/rtl/bba_front.sv]
// Front end: configuration register, item intake and command classification.
`timescale 1ns / 1ps

module bba_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [bba_pkg::LEN_W-1:0]    cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bba_pkg::FUNC_W-1:0]   func,
    input  logic [bba_pkg::BLK_W-1:0]    block_index,
    input  logic [bba_pkg::LEN_W-1:0]    run_length,
    input  logic                         q_full,
    output logic                         push,
    output bba_pkg::cmd_t                push_cmd
);

    logic [bba_pkg::LEN_W-1:0]      blk_limit_reg;
    logic [bba_pkg::LEN_W-1:0]      clamped;
    logic [bba_pkg::WCNT_W-1:0]     nwords;
    logic [bba_pkg::LEN_W-1:0]      limit;
    logic                           in_range;
    logic                           len_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_limit_reg <= bba_pkg::LEN_W'(bba_pkg::MAX_BLOCKS);
        end
        else if (cfg_wr_en)
        begin
            blk_limit_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        clamped  = (blk_limit_reg > bba_pkg::LEN_W'(bba_pkg::MAX_BLOCKS)) ?
                   bba_pkg::LEN_W'(bba_pkg::MAX_BLOCKS) : blk_limit_reg;
        nwords   = bba_pkg::WCNT_W'(clamped >> bba_pkg::BIT_IDX_W);
        limit    = bba_pkg::LEN_W'({nwords, {bba_pkg::BIT_IDX_W{1'b0}}});
        in_range = bba_pkg::WCNT_W'(block_index[bba_pkg::BLK_W-1:bba_pkg::BIT_IDX_W]) < nwords;
        len_ok   = (run_length != '0) && (run_length <= limit);

        push_cmd.word_idx = block_index[bba_pkg::BLK_W-1:bba_pkg::BIT_IDX_W];
        push_cmd.bit_idx  = block_index[bba_pkg::BIT_IDX_W-1:0];
        push_cmd.len      = run_length;
        push_cmd.nwords   = nwords;

        unique case (func)
            bba_pkg::FUNC_MARK_USED: push_cmd.op = in_range ? bba_pkg::OP_SET : bba_pkg::OP_NONE;
            bba_pkg::FUNC_MARK_FREE: push_cmd.op = in_range ? bba_pkg::OP_CLR : bba_pkg::OP_NONE;
            bba_pkg::FUNC_TEST:      push_cmd.op = in_range ? bba_pkg::OP_TEST :
                                                              bba_pkg::OP_TEST_OOR;
            bba_pkg::FUNC_FIND:      push_cmd.op = len_ok ? bba_pkg::OP_FIND : bba_pkg::OP_NONE;
            bba_pkg::FUNC_MARK_ALL:  push_cmd.op = bba_pkg::OP_ALL;
            default:                 push_cmd.op = bba_pkg::OP_NONE;
        endcase
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

endmodule

[hw/rtl/bba_cmd_queue.sv]
// Short command queue between the front end and the execution engine.
`timescale 1ns / 1ps

module bba_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bba_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output bba_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = (bba_pkg::QUEUE_DEPTH > 1) ? $clog2(bba_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(bba_pkg::QUEUE_DEPTH + 1);

    bba_pkg::cmd_t     entries [bba_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(bba_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entries[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(bba_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(bba_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/bba_back.sv]
// Execution engine: bitmap memory, mark and test access, and pipelined free-run search.
`timescale 1ns / 1ps

module bba_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  bba_pkg::cmd_t               q_cmd,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        block_used,
    output logic                        found,
    output logic [bba_pkg::BLK_W-1:0]   start_block
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCESS,
        S_FIND,
        S_EMIT
    } state_t;

    localparam int W  = bba_pkg::WORD_BITS;
    localparam int WI = bba_pkg::WORD_IDX_W;
    localparam int BI = bba_pkg::BIT_IDX_W;
    localparam int LW = bba_pkg::LEN_W;
    localparam int RW = bba_pkg::RUN_W;

    logic [W-1:0]              mem [bba_pkg::NUM_WORDS];
    logic [W-1:0]              mem_q;
    logic [bba_pkg::NUM_WORDS-1:0] vb;
    logic                      vb_q;
    logic [WI-1:0]             rd_addr;
    logic                      wr_en;
    logic [W-1:0]              wr_data;
    logic                      clr_all;
    logic [W-1:0]              rd_word;

    state_t                    state_reg, state_next;
    logic                      s1_valid_reg, s1_valid_next;
    logic                      s2_valid_reg, s2_valid_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_used_reg, out_used_next;
    logic                      out_found_reg, out_found_next;
    logic [bba_pkg::BLK_W-1:0] out_start_reg, out_start_next;

    bba_pkg::op_t              cur_op_reg, cur_op_next;
    logic [WI-1:0]             cur_word_reg, cur_word_next;
    logic [BI-1:0]             cur_bit_reg, cur_bit_next;
    logic [LW-1:0]             cur_len_reg, cur_len_next;
    logic [bba_pkg::WCNT_W-1:0] cur_nw_reg, cur_nw_next;
    logic [bba_pkg::WCNT_W-1:0] issue_reg, issue_next;
    logic [WI-1:0]             s1_idx_reg, s1_idx_next;
    logic [WI-1:0]             s2_idx_reg, s2_idx_next;
    logic [RW-1:0]             s2_lrun_reg [W];
    logic [RW-1:0]             lrun_c [W];
    logic [W-1:0]              s2_pre_reg, pre_c;
    logic [LW-1:0]             carry_reg, carry_next;
    logic                      res_used_reg, res_used_next;
    logic                      res_found_reg, res_found_next;
    logic [bba_pkg::BLK_W-1:0] res_start_reg, res_start_next;

    logic [LW-1:0]             total [W];
    logic [W-1:0]              hit;
    logic [BI-1:0]             hit_pos;
    logic [LW-1:0]             start_c;
    logic [W-1:0]              bit_mask;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cur_word_reg] <= wr_data;
        end
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb   <= '0;
            vb_q <= 1'b0;
        end
        else
        begin
            if (clr_all)
            begin
                vb <= '0;
            end
            else if (wr_en)
            begin
                vb[cur_word_reg] <= 1'b1;
            end
            vb_q <= vb[rd_addr];
        end
    end

    assign rd_word  = vb_q ? mem_q : '1;
    assign bit_mask = W'(1) << cur_bit_reg;

    // Per bit: length of the free run ending there inside the word, and whether
    // that run reaches down to bit zero and so continues from the previous word.
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            lrun_c[i] = RW'(i + 1);
            pre_c[i]  = 1'b1;
            for (int j = 0; j < W; j++)
            begin
                if (j <= i && rd_word[j])
                begin
                    lrun_c[i] = RW'(i - j);
                    pre_c[i]  = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            total[i] = s2_pre_reg[i] ? carry_reg + LW'(s2_lrun_reg[i]) : LW'(s2_lrun_reg[i]);
            hit[i]   = (total[i] >= cur_len_reg);
        end
        hit_pos = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_pos = BI'(i);
            end
        end
        start_c = LW'({s2_idx_reg, hit_pos}) + LW'(1) - cur_len_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        out_used_next  = out_used_reg;
        out_found_next = out_found_reg;
        out_start_next = out_start_reg;
        cur_op_next    = cur_op_reg;
        cur_word_next  = cur_word_reg;
        cur_bit_next   = cur_bit_reg;
        cur_len_next   = cur_len_reg;
        cur_nw_next    = cur_nw_reg;
        issue_next     = issue_reg;
        s1_idx_next    = s1_idx_reg;
        s2_idx_next    = s2_idx_reg;
        carry_next     = carry_reg;
        res_used_next  = res_used_reg;
        res_found_next = res_found_reg;
        res_start_next = res_start_reg;
        rd_addr        = q_cmd.word_idx;
        wr_en          = 1'b0;
        wr_data        = rd_word;
        clr_all        = 1'b0;
        q_pop          = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    cur_op_next    = q_cmd.op;
                    cur_word_next  = q_cmd.word_idx;
                    cur_bit_next   = q_cmd.bit_idx;
                    cur_len_next   = q_cmd.len;
                    cur_nw_next    = q_cmd.nwords;
                    res_used_next  = 1'b0;
                    res_found_next = 1'b0;
                    res_start_next = '0;
                    unique case (q_cmd.op)
                        bba_pkg::OP_SET,
                        bba_pkg::OP_CLR,
                        bba_pkg::OP_TEST:
                        begin
                            state_next = S_ACCESS;
                        end
                        bba_pkg::OP_TEST_OOR:
                        begin
                            res_used_next = 1'b1;
                            state_next    = S_EMIT;
                        end
                        bba_pkg::OP_FIND:
                        begin
                            issue_next    = '0;
                            carry_next    = '0;
                            s1_valid_next = 1'b0;
                            s2_valid_next = 1'b0;
                            state_next    = S_FIND;
                        end
                        bba_pkg::OP_ALL:
                        begin
                            clr_all    = 1'b1;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_ACCESS:
            begin
                unique case (cur_op_reg)
                    bba_pkg::OP_SET:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_word | bit_mask;
                    end
                    bba_pkg::OP_CLR:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_word & ~bit_mask;
                    end
                    default:
                    begin
                        res_used_next = rd_word[cur_bit_reg];
                    end
                endcase
                state_next = S_EMIT;
            end
            S_FIND:
            begin
                s1_valid_next = 1'b0;
                if (issue_reg < cur_nw_reg)
                begin
                    rd_addr       = issue_reg[WI-1:0];
                    s1_valid_next = 1'b1;
                    s1_idx_next   = issue_reg[WI-1:0];
                    issue_next    = issue_reg + 1'b1;
                end
                s2_valid_next = s1_valid_reg;
                s2_idx_next   = s1_idx_reg;
                if (s2_valid_reg)
                begin
                    carry_next = total[W-1];
                    if (hit != '0)
                    begin
                        res_found_next = 1'b1;
                        res_start_next = start_c[bba_pkg::BLK_W-1:0];
                        s1_valid_next  = 1'b0;
                        s2_valid_next  = 1'b0;
                        state_next     = S_EMIT;
                    end
                    else if (bba_pkg::WCNT_W'(s2_idx_reg) == cur_nw_reg - 1'b1)
                    begin
                        s1_valid_next = 1'b0;
                        s2_valid_next = 1'b0;
                        state_next    = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_used_next  = res_used_reg;
                    out_found_next = res_found_reg;
                    out_start_next = res_start_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_used_reg  <= 1'b0;
            out_found_reg <= 1'b0;
            out_start_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            out_used_reg  <= out_used_next;
            out_found_reg <= out_found_next;
            out_start_reg <= out_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_op_reg    <= cur_op_next;
        cur_word_reg  <= cur_word_next;
        cur_bit_reg   <= cur_bit_next;
        cur_len_reg   <= cur_len_next;
        cur_nw_reg    <= cur_nw_next;
        issue_reg     <= issue_next;
        s1_idx_reg    <= s1_idx_next;
        s2_idx_reg    <= s2_idx_next;
        s2_lrun_reg   <= lrun_c;
        s2_pre_reg    <= pre_c;
        carry_reg     <= carry_next;
        res_used_reg  <= res_used_next;
        res_found_reg <= res_found_next;
        res_start_reg <= res_start_next;
    end

    assign out_valid   = out_valid_reg;
    assign block_used  = out_used_reg;
    assign found       = out_found_reg;
    assign start_block = out_start_reg;

endmodule

[hw/rtl/bba_checker.sv]
// Port-level checks of the bitmap block allocator and their binding to the top level.
`timescale 1ns / 1ps

module bba_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        block_used,
    input  logic                        found,
    input  logic [bba_pkg::BLK_W-1:0]   start_block
);

    // A result that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_used) && $stable(found)
                                    && $stable(start_block))
        else $error("stalled result changed or dropped");

    // A result carries either a test answer or a find answer, never both.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(block_used && found))
        else $error("result reports both used and found");

    // Without a located run the start block reads zero.
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> start_block == '0)
        else $error("start block nonzero without a found run");

    // No result is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (.*);
